/* design/ssb_pkg.sv */
// Shared constants, payload types and controller/datapath interface structs.
package ssb_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int CUR_W        = $clog2(MAX_ELEMENTS + 2);
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int VALUE_W      = 16;
    localparam int TARGET_W     = 20;
    localparam int SUM_W        = 21;
    localparam int MASK_W       = 16;
    localparam int COUNT_W      = 16;
    localparam int MASK_LIMIT   = 63;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    // register index codes
    localparam logic REG_TARGET_SUM = 1'b0;

    // result kinds
    localparam logic KIND_MASK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] element_value;
        logic               last_element;
    } item_t;

    typedef struct packed {
        logic               result_kind;
        logic [MASK_W-1:0]  subset_mask;
        logic [COUNT_W-1:0] solution_count;
        logic               truncated;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic load;
        logic start;
        logic fetch;
        logic eval;
        logic scan;
        logic bsub;
        logic summary;
    } ssb_cmd_t;

    typedef struct packed {
        logic cur_le_n;
        logic trial_eq;
        logic emit_ok;
        logic scan_zero;
        logic scan_marked;
        logic out_free;
    } ssb_status_t;

endpackage

/* design/ssb_ctrl.sv */
// Search controller: sequences load, forward steps, backtracking and summary.
module ssb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_last,
    output logic                item_ready,
    input  ssb_pkg::ssb_status_t status,
    output ssb_pkg::ssb_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_FETCH,
        ST_EVAL,
        ST_SCAN,
        ST_BSUB,
        ST_SUMMARY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_last)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (status.cur_le_n)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_EVAL;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_EVAL:
            begin
                // a hit that must be shown waits for the output register
                if (!(status.trial_eq && status.emit_ok && !status.out_free))
                begin
                    cmd.eval   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_zero)
                begin
                    state_next = ST_SUMMARY;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (status.scan_marked)
                    begin
                        state_next = ST_BSUB;
                    end
                end
            end
            ST_BSUB:
            begin
                cmd.bsub   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                begin
                    cmd.summary = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/ssb_datapath.sv */
// Search datapath: element store, marks, running sum, cursor, hit count, output register.
module ssb_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ssb_pkg::item_t                       item,
    input  logic [ssb_pkg::TARGET_W-1:0]         target_sum,
    input  ssb_pkg::ssb_cmd_t                    cmd,
    output ssb_pkg::ssb_status_t                 status,
    output ssb_pkg::result_t                     result,
    output logic                                 result_valid,
    input  logic                                 result_ready
);

    logic [ssb_pkg::VALUE_W-1:0]      store_mem [ssb_pkg::MAX_ELEMENTS];
    logic [ssb_pkg::VALUE_W-1:0]      rd_data_reg;
    logic [ssb_pkg::CUR_W-1:0]        load_pos_reg, load_pos_next;
    logic [ssb_pkg::CUR_W-1:0]        cursor_reg, cursor_next;
    logic [ssb_pkg::MAX_ELEMENTS-1:0] marks_reg, marks_next;
    logic [ssb_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [ssb_pkg::COUNT_W-1:0]      hit_reg, hit_next;
    ssb_pkg::result_t                 result_reg, result_next;
    logic                             result_valid_reg, result_valid_next;

    logic [ssb_pkg::CUR_W-1:0]   cursor_dec, cursor_inc, cursor_dec2;
    logic [ssb_pkg::IDX_W-1:0]   rd_idx, cur_idx, scan_idx;
    logic                        rd_en;
    logic                        store_free;
    logic [ssb_pkg::SUM_W-1:0]   trial, target_ext;
    logic [ssb_pkg::COUNT_W-1:0] hit_inc;
    logic                        out_free;

    assign cursor_dec  = cursor_reg - 1'b1;
    assign cursor_inc  = cursor_reg + 1'b1;
    assign cursor_dec2 = cursor_reg - ssb_pkg::CUR_W'(2);
    assign cur_idx     = cursor_dec[ssb_pkg::IDX_W-1:0];
    assign scan_idx    = cursor_dec2[ssb_pkg::IDX_W-1:0];
    assign store_free  = load_pos_reg < ssb_pkg::CUR_W'(ssb_pkg::MAX_ELEMENTS);
    assign trial       = sum_reg + ssb_pkg::SUM_W'(rd_data_reg);
    assign target_ext  = ssb_pkg::SUM_W'(target_sum);
    assign hit_inc     = (hit_reg == '1) ? hit_reg : hit_reg + 1'b1;
    assign out_free    = !result_valid_reg || result_ready;

    assign status.cur_le_n    = cursor_reg <= load_pos_reg;
    assign status.trial_eq    = trial == target_ext;
    assign status.emit_ok     = hit_reg < ssb_pkg::COUNT_W'(ssb_pkg::MASK_LIMIT);
    assign status.scan_zero   = cursor_dec == '0;
    assign status.scan_marked = marks_reg[scan_idx];
    assign status.out_free    = out_free;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        load_pos_next     = load_pos_reg;
        cursor_next       = cursor_reg;
        marks_next        = marks_reg;
        sum_next          = sum_reg;
        hit_next          = hit_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        rd_en             = 1'b0;
        rd_idx            = cur_idx;

        if (cmd.load && store_free)
        begin
            load_pos_next = load_pos_reg + 1'b1;
        end

        if (cmd.start)
        begin
            marks_next    = '0;
            marks_next[0] = 1'b1;
            sum_next      = '0;
            hit_next      = '0;
            cursor_next   = ssb_pkg::CUR_W'(1);
        end

        if (cmd.fetch)
        begin
            rd_en = 1'b1;
        end

        if (cmd.eval)
        begin
            if (trial == target_ext)
            begin
                hit_next = hit_inc;
                if (hit_reg < ssb_pkg::COUNT_W'(ssb_pkg::MASK_LIMIT))
                begin
                    result_next.result_kind    = ssb_pkg::KIND_MASK;
                    result_next.subset_mask    = ssb_pkg::MASK_W'(marks_reg);
                    result_next.solution_count = hit_inc;
                    result_next.truncated      = 1'b0;
                    result_next.last_result    = 1'b0;
                    result_valid_next          = 1'b1;
                end
                marks_next[cur_idx] = 1'b0;
            end
            else if (trial < target_ext)
            begin
                sum_next = trial;
            end
            else
            begin
                marks_next[cur_idx] = 1'b0;
            end
        end

        if (cmd.scan)
        begin
            cursor_next = cursor_dec;
            if (marks_reg[scan_idx])
            begin
                marks_next[scan_idx] = 1'b0;
                rd_en                = 1'b1;
                rd_idx               = scan_idx;
            end
        end

        if (cmd.bsub)
        begin
            sum_next = sum_reg - ssb_pkg::SUM_W'(rd_data_reg);
        end

        // step forward and include the next element
        if (cmd.eval || cmd.bsub)
        begin
            cursor_next = cursor_inc;
            if (cursor_reg < load_pos_reg)
            begin
                marks_next[cursor_reg[ssb_pkg::IDX_W-1:0]] = 1'b1;
            end
        end

        if (cmd.summary)
        begin
            result_next.result_kind    = ssb_pkg::KIND_SUMMARY;
            result_next.subset_mask    = '0;
            result_next.solution_count = hit_reg;
            result_next.truncated      = hit_reg > ssb_pkg::COUNT_W'(ssb_pkg::MASK_LIMIT);
            result_next.last_result    = 1'b1;
            result_valid_next          = 1'b1;
            load_pos_next              = '0;
            cursor_next                = '0;
            marks_next                 = '0;
            sum_next                   = '0;
            hit_next                   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_free)
        begin
            store_mem[load_pos_reg[ssb_pkg::IDX_W-1:0]] <= item.element_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_idx];
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg     <= '0;
            cursor_reg       <= '0;
            marks_reg        <= '0;
            sum_reg          <= '0;
            hit_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            load_pos_reg     <= load_pos_next;
            cursor_reg       <= cursor_next;
            marks_reg        <= marks_next;
            sum_reg          <= sum_next;
            hit_reg          <= hit_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

/* design/subset_sum_backtrack_core.sv */
// Top level of the sum-of-subsets backtracking search core.
//
// Usage:
//   Requests on the item channel (item_valid/item_ready, payload item) load set
//   elements one per cycle into positions one upwards; at most 16 are kept and
//   further ones are dropped. The request with last_element set starts a
//   depth-first backtracking search against target_sum (APB register at
//   address 0). item_ready stays low from then until the summary is taken
//   into the output register.
//   Each hit leaves on the result channel (result_valid/result_ready) as a
//   membership mask with its ordinal; at most 63 masks are sent. A summary
//   with the saturating hit count, the truncated flag and last_result set
//   closes the run, after which the next set can be loaded.
// Sequencing:
//   The search is a loop through the shared element store, whose read port
//   is registered: each forward step is a fetch followed by an evaluate;
//   each backtrack is a fetch that finds the end of the set, a scan down
//   the positions to the latest included element, and a subtract. A run
//   opens with a start step and ends with a scan down to position one and
//   a summary step.
// Stalls: a single output register decouples the search; while a result
//   waits unclaimed the search holds at a mask-sending hit or the summary.
// Reset: rst_n (asynchronous, active low) clears the controller, load
//   position, marks, sums, counters and target_sum; stored elements are not
//   cleared, they are always written before being read.
module subset_sum_backtrack_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         item_valid,
    output logic                         item_ready,
    input  ssb_pkg::item_t               item,
    // result channel
    output logic                         result_valid,
    input  logic                         result_ready,
    output ssb_pkg::result_t             result,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssb_pkg::ADDR_W-1:0]   paddr,
    input  logic [ssb_pkg::DATA_W-1:0]   pwdata,
    output logic [ssb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    ssb_pkg::ssb_cmd_t    cmd;
    ssb_pkg::ssb_status_t status;

    logic [ssb_pkg::TARGET_W-1:0] target_sum_reg, target_sum_next;
    logic                         reg_sel;

    // word select; byte offset bits are ignored
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        target_sum_next = target_sum_reg;
        if (psel && penable && pwrite && reg_sel == ssb_pkg::REG_TARGET_SUM)
        begin
            target_sum_next = pwdata[ssb_pkg::TARGET_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == ssb_pkg::REG_TARGET_SUM)
        begin
            prdata = ssb_pkg::DATA_W'(target_sum_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
        end
        else
        begin
            target_sum_reg <= target_sum_next;
        end
    end

    ssb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_last  (item.last_element),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ssb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .target_sum   (target_sum_reg),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

/* dv/subset_sum_backtrack_core_test.sv */
// Self-checking testbench for the sum-of-subsets backtracking search core.
`timescale 1ns / 100ps

module subset_sum_backtrack_core_test;

    import ssb_pkg::*;

    // Random part stops once this many requests have gone in.
    localparam int RANDOM_REQUESTS = 70;
    // A full 16-element walk runs with no handshake on either channel;
    // the limit must outlast it.
    localparam int QUIET_LIMIT     = 2000000;
    // Cycles left after the last summary before the target is rewritten or the run ends.
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 32;
    localparam logic [ADDR_W-1:0] TARGET_ADDR = ADDR_W'(4 * REG_TARGET_SUM);

    // ------------------------------------------------------------------
    // Own model of the block: element store, load position and target.
    // Each request that closes a set is expanded into the masks and the
    // summary that the search must send, in order.
    // ------------------------------------------------------------------
    class hit_ledger;
        logic [TARGET_W-1:0] target;
        logic [VALUE_W-1:0]  elems [1:MAX_ELEMENTS];
        int                  load_pos;
        result_t             awaited [$];
        int                  mismatches;

        function new();
            target     = '0;
            load_pos   = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        // Depth-first walk over positions 1..n, one step per loop pass.
        function void walk_subsets();
            int                     n;
            int                     cur;
            int                     k;
            int                     total;
            logic [MAX_ELEMENTS-1:0] marks;
            logic [SUM_W-1:0]       run_sum;
            logic [SUM_W-1:0]       trial;
            logic [COUNT_W-1:0]     hits;
            result_t                r;

            n       = load_pos;
            marks   = '0;
            run_sum = '0;
            hits    = '0;
            total   = 0;
            cur     = 1;
            marks[0] = 1'b1;
            while (1)
            begin
                k = cur;
                if (k <= n && marks[k-1])
                begin
                    trial = run_sum + SUM_W'(elems[k]);
                    if (trial == SUM_W'(target))
                    begin
                        total++;
                        if (hits != '1)
                            hits++;
                        if (total <= MASK_LIMIT)
                        begin
                            r.result_kind    = KIND_MASK;
                            r.subset_mask    = MASK_W'(marks);
                            r.solution_count = hits;
                            r.truncated      = 1'b0;
                            r.last_result    = 1'b0;
                            awaited.push_back(r);
                        end
                        marks[k-1] = 1'b0;
                    end
                    else if (trial < SUM_W'(target))
                        run_sum = trial;
                    else
                        marks[k-1] = 1'b0;
                end
                else
                begin
                    // back up to the latest included element and drop it
                    k--;
                    while (k > 0 && !marks[k-1])
                        k--;
                    if (k == 0)
                        break;
                    marks[k-1] = 1'b0;
                    run_sum    = run_sum - SUM_W'(elems[k]);
                    cur        = k;
                end
                cur++;
                if (cur <= n)
                    marks[cur-1] = 1'b1;
            end
            r.result_kind    = KIND_SUMMARY;
            r.subset_mask    = '0;
            r.solution_count = hits;
            r.truncated      = (total > MASK_LIMIT);
            r.last_result    = 1'b1;
            awaited.push_back(r);
            load_pos = 0;
        endfunction

        function void take_request(input item_t req);
            // a full store drops the value, but a last flag still starts the search
            if (load_pos < MAX_ELEMENTS)
            begin
                load_pos++;
                elems[load_pos] = req.element_value;
            end
            if (req.last_element)
                walk_subsets();
        endfunction

        task check_result(input result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing awaited: %h", got));
                return;
            end
            want = awaited.pop_front();
            if (got.result_kind !== want.result_kind)
                report_mismatch($sformatf("result_kind %0d, want %0d",
                                          got.result_kind, want.result_kind));
            if (got.subset_mask !== want.subset_mask)
                report_mismatch($sformatf("subset_mask %h, want %h",
                                          got.subset_mask, want.subset_mask));
            if (got.solution_count !== want.solution_count)
                report_mismatch($sformatf("solution_count %0d, want %0d",
                                          got.solution_count, want.solution_count));
            if (got.truncated !== want.truncated)
                report_mismatch($sformatf("truncated %0d, want %0d",
                                          got.truncated, want.truncated));
            if (got.last_result !== want.last_result)
                report_mismatch($sformatf("last_result %0d, want %0d",
                                          got.last_result, want.last_result));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the signals of the block
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    item_t               item;
    logic                result_valid;
    logic                result_ready;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    hit_ledger           sb;
    int                  quiet_cycles;
    int                  burst_left;
    int                  sent_count;
    logic [15:0]         stall_pat;
    int                  stall_window;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    subset_sum_backtrack_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------
    // Monitor and watchdog, sampled at the rising edge. An accepted
    // request feeds the model; an accepted result is checked against the
    // oldest awaited one. The watchdog trips on a long spell without any
    // handshake on either channel.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.take_request(item);
            if (result_valid && result_ready)
                sb.check_result(result);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: result_ready follows a rotating 16-bit pattern that is
    // redrawn whenever its random window ends - sometimes all ones (no stalls),
    // sometimes sparse, sometimes dense. Never all zero, so it cannot lock.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_window = $urandom_range(200, 20);
            case ($urandom_range(3, 0))
                0:       stall_pat = '1;
                1:       stall_pat = 16'($urandom);
                2:       stall_pat = 16'($urandom & $urandom);
                default: stall_pat = 16'($urandom | $urandom);
            endcase
            if (stall_pat == '0)
                stall_pat = 16'h0001;
        end
        stall_window--;
        result_ready = stall_pat[0];
        stall_pat    = {stall_pat[0], stall_pat[15:1]};
    end

    // ------------------------------------------------------------------
    // Sender. Requests go out in bursts of random length; between bursts
    // item_valid drops for a random gap, if any. Inputs change on the falling edge.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [VALUE_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 0);
            if (gap > 0)
            begin
                @(negedge clk);
                item_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(8, 1);
        end
        burst_left--;
        @(negedge clk);
        item_valid         = 1'b1;
        item.element_value = value;
        item.last_element  = last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // One set: count elements, the final one flagged last. With mixed set,
    // about a quarter of the values are drawn over the whole 16-bit range.
    task automatic send_set(input int count, input int lo, input int hi, input bit mixed);
        logic [VALUE_W-1:0] v;
        for (int i = 1; i <= count; i++)
        begin
            if (mixed && $urandom_range(3, 0) == 0)
                v = VALUE_W'($urandom);
            else
                v = VALUE_W'($urandom_range(hi, lo));
            send_request(v, i == count);
        end
    endtask

    // Hold off new requests until every awaited result has come back.
    task automatic wait_drain();
        @(negedge clk);
        item_valid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of target_sum, then a read back of the same register.
    task automatic write_target(input logic [TARGET_W-1:0] value);
        logic [DATA_W-1:0] rd;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = TARGET_ADDR;
        pwdata  = DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.target = value;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== DATA_W'(value))
            sb.report_mismatch($sformatf("target_sum reads %h, wrote %h", rd, value));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int                  start_count;
        int                  phase;
        int                  n;
        int                  vmax;
        logic [TARGET_W-1:0] tgt;

        sb           = new();
        quiet_cycles = 0;
        burst_left   = 0;
        sent_count   = 0;
        stall_pat    = '1;
        stall_window = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Target still at its reset value of zero: a zero element is a hit
        // on its own, the maximum element overshoots.
        send_request(16'h0000, 1'b0);
        send_request(16'hFFFF, 1'b1);
        wait_drain();

        // Eight ones against four: 70 hits, only 63 masks, summary truncated.
        write_target(TARGET_W'(4));
        send_set(8, 1, 1, 1'b0);
        wait_drain();

        // Full store: sixteen maximum elements reach the target only all
        // together; a seventeenth, last request finds the store full and is
        // dropped, yet still starts the (exhaustive) search.
        write_target(TARGET_W'(16 * 65535));
        repeat (MAX_ELEMENTS) send_request(16'hFFFF, 1'b0);
        send_request(16'h0000, 1'b1);
        wait_drain();

        // Random phases: one target per phase, a few sets each. The first two
        // phases take the extremes of the target.
        start_count = sent_count;
        phase       = 0;
        while (sent_count - start_count < RANDOM_REQUESTS)
        begin
            if (phase == 0)
                tgt = '0;
            else if (phase == 1)
                tgt = '1;
            else
            begin
                case ($urandom_range(4, 0))
                    0:       tgt = TARGET_W'($urandom_range(64, 1));
                    1:       tgt = TARGET_W'($urandom_range(4096, 65));
                    2:       tgt = TARGET_W'($urandom_range(65535, 4097));
                    3:       tgt = TARGET_W'($urandom_range(20'hFFFFF, 65536));
                    default: tgt = TARGET_W'($urandom_range(16, 0));
                endcase
            end
            write_target(tgt);
            repeat ($urandom_range(4, 2))
            begin
                if (tgt < 65535 && $urandom_range(7, 0) == 0)
                begin
                    // overlong set: everything above the target, tail dropped
                    send_set($urandom_range(20, 17), int'(tgt) + 1, 65535, 1'b0);
                end
                else
                begin
                    // values scaled so that some subsets meet the target
                    n    = $urandom_range(10, 1);
                    vmax = (2 * int'(tgt)) / n + 1;
                    if (vmax > 65535)
                        vmax = 65535;
                    send_set(n, 0, vmax, 1'b1);
                end
                if ($urandom_range(3, 0) == 0)
                    wait_drain();
            end
            wait_drain();
            phase++;
        end

        wait_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/ssb_pkg.sv
design/ssb_ctrl.sv
design/ssb_datapath.sv
design/subset_sum_backtrack_core.sv
dv/subset_sum_backtrack_core_test.sv
